// ===== src/urhd_pkg.sv =====
// Shared types and constants for the UDP relay header deframer.
`default_nettype none
package urhd_pkg;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_ADDR    = 3'd1,
        ROLE_PORT    = 3'd2,
        ROLE_LENGTH  = 3'd3,
        ROLE_SEP     = 3'd4,
        ROLE_PAYLOAD = 3'd5,
        ROLE_IGNORED = 3'd6
    } role_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_OK       = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_BAD_SEP  = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    localparam logic [1:0] KIND_V4   = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_V6   = 2'd2;

    localparam logic [7:0] ATYPE_V4   = 8'h01;
    localparam logic [7:0] ATYPE_NAME = 8'h03;
    localparam logic [7:0] ATYPE_V6   = 8'h04;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [16:0] HDR_V4    = 17'd7;
    localparam logic [16:0] HDR_V6    = 17'd19;
    localparam logic [16:0] HDR_EXTRA = 17'd4;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]  data;
        role_t       role;
        status_t     status;   // parser status, before truncation check
        logic [1:0]  kind;
        logic [15:0] port;
        logic [15:0] length;
        logic [16:0] consumed;
        logic        last;
    } rec_t;

endpackage
`default_nettype wire

// ===== src/urhd_front.sv =====
// Front end: byte acceptance and the header parse machine.
`default_nettype none
module urhd_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_frame_last,
    input  wire logic         q_ready,
    output logic              q_valid,
    output urhd_pkg::rec_t    q_rec
);

    typedef enum logic [3:0] {
        PH_TYPE    = 4'd0,
        PH_DLEN    = 4'd1,
        PH_ADDR    = 4'd2,
        PH_PORT_HI = 4'd3,
        PH_PORT_LO = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_LEN_LO  = 4'd6,
        PH_CR      = 4'd7,
        PH_LF      = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_IGNORE  = 4'd10
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        dlen_reg, dlen_next;
    logic [15:0]       port_reg, port_next;
    logic [15:0]       len_reg, len_next;
    logic [16:0]       cons_reg, cons_next;
    urhd_pkg::status_t stat_reg, stat_next;
    urhd_pkg::role_t   role;
    logic [15:0]       cnt_dec;
    logic [16:0]       hdr;
    logic              finish;
    logic              accept;

    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && q_ready;
    assign cnt_dec = cnt_reg - 16'd1;

    always_comb begin
        unique case (kind_reg)
            urhd_pkg::KIND_V4:   hdr = urhd_pkg::HDR_V4;
            urhd_pkg::KIND_NAME: hdr = {9'd0, dlen_reg} + urhd_pkg::HDR_EXTRA;
            default:             hdr = urhd_pkg::HDR_V6;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        dlen_next  = dlen_reg;
        port_next  = port_reg;
        len_next   = len_reg;
        stat_next  = stat_reg;
        finish     = 1'b0;
        role       = urhd_pkg::ROLE_IGNORED;
        unique case (phase_reg)
            PH_TYPE: begin
                role = urhd_pkg::ROLE_TYPE;
                if (s_data_byte == urhd_pkg::ATYPE_V4) begin
                    kind_next  = urhd_pkg::KIND_V4;
                    cnt_next   = 16'd4;
                    phase_next = PH_ADDR;
                end else if (s_data_byte == urhd_pkg::ATYPE_NAME) begin
                    kind_next  = urhd_pkg::KIND_NAME;
                    phase_next = PH_DLEN;
                end else if (s_data_byte == urhd_pkg::ATYPE_V6) begin
                    kind_next  = urhd_pkg::KIND_V6;
                    cnt_next   = 16'd16;
                    phase_next = PH_ADDR;
                end else begin
                    stat_next  = urhd_pkg::ST_BAD_TYPE;
                    phase_next = PH_IGNORE;
                end
            end
            PH_DLEN: begin
                role      = urhd_pkg::ROLE_ADDR;
                dlen_next = s_data_byte;
                if (s_data_byte == 8'd0) begin
                    phase_next = PH_PORT_HI;
                end else begin
                    cnt_next   = {8'd0, s_data_byte};
                    phase_next = PH_ADDR;
                end
            end
            PH_ADDR: begin
                role     = urhd_pkg::ROLE_ADDR;
                cnt_next = cnt_dec;
                if (cnt_dec == 16'd0) begin
                    phase_next = PH_PORT_HI;
                end
            end
            PH_PORT_HI: begin
                role       = urhd_pkg::ROLE_PORT;
                port_next  = {s_data_byte, 8'd0};
                phase_next = PH_PORT_LO;
            end
            PH_PORT_LO: begin
                role       = urhd_pkg::ROLE_PORT;
                port_next  = {port_reg[15:8], s_data_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                role       = urhd_pkg::ROLE_LENGTH;
                len_next   = {s_data_byte, 8'd0};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                role       = urhd_pkg::ROLE_LENGTH;
                len_next   = {len_reg[15:8], s_data_byte};
                phase_next = PH_CR;
            end
            PH_CR: begin
                role = urhd_pkg::ROLE_SEP;
                if (s_data_byte != urhd_pkg::CHAR_CR) begin
                    stat_next  = urhd_pkg::ST_BAD_SEP;
                    phase_next = PH_IGNORE;
                end else begin
                    phase_next = PH_LF;
                end
            end
            PH_LF: begin
                role = urhd_pkg::ROLE_SEP;
                if (s_data_byte != urhd_pkg::CHAR_LF) begin
                    stat_next  = urhd_pkg::ST_BAD_SEP;
                    phase_next = PH_IGNORE;
                end else if (len_reg == 16'd0) begin
                    finish = 1'b1;
                end else begin
                    cnt_next   = len_reg;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role     = urhd_pkg::ROLE_PAYLOAD;
                cnt_next = cnt_dec;
                if (cnt_dec == 16'd0) begin
                    finish = 1'b1;
                end
            end
            default: begin
                role = urhd_pkg::ROLE_IGNORED;
            end
        endcase
        cons_next = cons_reg;
        if (finish) begin
            stat_next  = urhd_pkg::ST_OK;
            cons_next  = hdr + urhd_pkg::HDR_EXTRA + {1'b0, len_reg};
            phase_next = PH_IGNORE;
        end
    end

    always_comb begin
        q_rec.data     = s_data_byte;
        q_rec.role     = role;
        q_rec.status   = stat_next;
        q_rec.kind     = kind_next;
        q_rec.port     = port_next;
        q_rec.length   = len_next;
        q_rec.consumed = cons_next;
        q_rec.last     = s_frame_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_frame_last)) begin
            phase_reg <= PH_TYPE;
            cnt_reg   <= '0;
            kind_reg  <= '0;
            dlen_reg  <= '0;
            port_reg  <= '0;
            len_reg   <= '0;
            cons_reg  <= '0;
            stat_reg  <= urhd_pkg::ST_BUSY;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            dlen_reg  <= dlen_next;
            port_reg  <= port_next;
            len_reg   <= len_next;
            cons_reg  <= cons_next;
            stat_reg  <= stat_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/urhd_queue.sv =====
// Two-entry queue of classified bytes between front and back.
`default_nettype none
module urhd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire urhd_pkg::rec_t wr_rec,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output urhd_pkg::rec_t      rd_rec
);

    urhd_pkg::rec_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/urhd_back.sv =====
// Back end: final status, consumed-count gating and the output register.
`default_nettype none
module urhd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire urhd_pkg::rec_t q_rec,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic [2:0]          m_byte_role,
    output logic [2:0]          m_status,
    output logic [1:0]          m_address_kind,
    output logic [15:0]         m_port_number,
    output logic [15:0]         m_payload_length,
    output logic [16:0]         m_consumed_count,
    output logic                m_frame_done
);

    logic              valid_reg;
    logic [7:0]        byte_reg;
    logic [2:0]        role_reg;
    logic [2:0]        status_reg;
    logic [1:0]        kind_reg;
    logic [15:0]       port_reg;
    logic [15:0]       len_reg;
    logic [16:0]       cons_reg;
    logic              done_reg;
    urhd_pkg::status_t status_next;
    logic [16:0]       cons_next;

    assign q_ready = !valid_reg || m_ready;

    // a last byte with the parse still running means the frame was cut short
    always_comb begin
        status_next = q_rec.status;
        if (q_rec.last && q_rec.status == urhd_pkg::ST_BUSY) begin
            status_next = urhd_pkg::ST_TRUNC;
        end
        cons_next = (status_next == urhd_pkg::ST_OK) ? q_rec.consumed : 17'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_ready) begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            byte_reg   <= q_rec.data;
            role_reg   <= q_rec.role;
            status_reg <= status_next;
            kind_reg   <= q_rec.kind;
            port_reg   <= q_rec.port;
            len_reg    <= q_rec.length;
            cons_reg   <= cons_next;
            done_reg   <= q_rec.last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_byte_role      = role_reg;
    assign m_status         = status_reg;
    assign m_address_kind   = kind_reg;
    assign m_port_number    = port_reg;
    assign m_payload_length = len_reg;
    assign m_consumed_count = cons_reg;
    assign m_frame_done     = done_reg;

endmodule
`default_nettype wire

// ===== src/udp_relay_header_deframer.sv =====
// Top level: UDP relay header deframer (front parser, queue, output stage).
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   bytes   | s_valid/s_ready, s_data_byte, | in
//           | s_frame_last                  |
//   results | m_valid/m_ready, m_out_byte,  | out
//           | m_byte_role .. m_frame_done   |
//
// One byte per cycle while the queue is not full; a result passes through a queue entry and then the output register.
// The parse machine updates on acceptance; the two-entry queue and the output
// register together hold up to three results while the output stalls.
// s_ready drops only when the queue is full.
// Synchronous active-low reset clears the parse state and empties the pipeline.
`default_nettype none
module udp_relay_header_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [2:0]       m_byte_role,
    output logic [2:0]       m_status,
    output logic [1:0]       m_address_kind,
    output logic [15:0]      m_port_number,
    output logic [15:0]      m_payload_length,
    output logic [16:0]      m_consumed_count,
    output logic             m_frame_done
);

    logic           fq_valid, fq_ready;
    urhd_pkg::rec_t fq_rec;
    logic           qb_valid, qb_ready;
    urhd_pkg::rec_t qb_rec;

    urhd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_frame_last (s_frame_last),
        .q_ready      (fq_ready),
        .q_valid      (fq_valid),
        .q_rec        (fq_rec)
    );

    urhd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_rec   (fq_rec),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_rec   (qb_rec)
    );

    urhd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (qb_valid),
        .q_ready          (qb_ready),
        .q_rec            (qb_rec),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_role      (m_byte_role),
        .m_status         (m_status),
        .m_address_kind   (m_address_kind),
        .m_port_number    (m_port_number),
        .m_payload_length (m_payload_length),
        .m_consumed_count (m_consumed_count),
        .m_frame_done     (m_frame_done)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the UDP relay header deframer: directed and random datagrams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic [3:0] {
        PH_TYPE, PH_DLEN, PH_ADDR, PH_PORT_HI, PH_PORT_LO,
        PH_LEN_HI, PH_LEN_LO, PH_CR, PH_LF, PH_PAYLOAD, PH_IGNORE
    } phase_t;

    typedef struct {
        logic [7:0]        data;
        urhd_pkg::role_t   role;
        urhd_pkg::status_t status;
        logic [1:0]        kind;
        logic [15:0]       port;
        logic [15:0]       length;
        logic [16:0]       consumed;
        logic              done;
    } beat_t;

    typedef logic [7:0] octet_q_t [$];

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [7:0]  m_out_byte;
    logic [2:0]  m_byte_role;
    logic [2:0]  m_status;
    logic [1:0]  m_address_kind;
    logic [15:0] m_port_number;
    logic [15:0] m_payload_length;
    logic [16:0] m_consumed_count;
    logic        m_frame_done;

    udp_relay_header_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_frame_last     (s_frame_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_role      (m_byte_role),
        .m_status         (m_status),
        .m_address_kind   (m_address_kind),
        .m_port_number    (m_port_number),
        .m_payload_length (m_payload_length),
        .m_consumed_count (m_consumed_count),
        .m_frame_done     (m_frame_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser mirror
    phase_t            phase_q;
    logic [15:0]       remaining;
    logic [1:0]        kind_q;
    logic [7:0]        name_len;
    logic [15:0]       port_q;
    logic [15:0]       len_q;
    logic [16:0]       consumed_q;
    urhd_pkg::status_t status_q;

    beat_t expected_beats [$];
    int    err_count = 0;
    int    sent_count = 0;
    bit    idle_on = 1'b1;
    int    rx_hold = 0;
    int    stall_cycles = 0;

    task automatic clear_parser();
        phase_q    = PH_TYPE;
        remaining  = '0;
        kind_q     = urhd_pkg::KIND_V4;
        name_len   = '0;
        port_q     = '0;
        len_q      = '0;
        consumed_q = '0;
        status_q   = urhd_pkg::ST_BUSY;
    endtask

    task automatic close_frame_ok();
        logic [16:0] hdr;
        if (kind_q == urhd_pkg::KIND_V4) begin
            hdr = urhd_pkg::HDR_V4;
        end else if (kind_q == urhd_pkg::KIND_NAME) begin
            hdr = {9'd0, name_len} + urhd_pkg::HDR_EXTRA;
        end else begin
            hdr = urhd_pkg::HDR_V6;
        end
        status_q   = urhd_pkg::ST_OK;
        consumed_q = hdr + urhd_pkg::HDR_EXTRA + {1'b0, len_q};
        phase_q    = PH_IGNORE;
    endtask

    // advance the mirror by one accepted byte and queue the result it must produce
    task automatic classify_byte(input logic [7:0] b, input logic last);
        beat_t e;
        e.role = urhd_pkg::ROLE_IGNORED;
        case (phase_q)
            PH_TYPE: begin
                e.role = urhd_pkg::ROLE_TYPE;
                if (b == urhd_pkg::ATYPE_V4) begin
                    kind_q = urhd_pkg::KIND_V4; remaining = 16'd4; phase_q = PH_ADDR;
                end else if (b == urhd_pkg::ATYPE_NAME) begin
                    kind_q = urhd_pkg::KIND_NAME; phase_q = PH_DLEN;
                end else if (b == urhd_pkg::ATYPE_V6) begin
                    kind_q = urhd_pkg::KIND_V6; remaining = 16'd16; phase_q = PH_ADDR;
                end else begin
                    status_q = urhd_pkg::ST_BAD_TYPE; phase_q = PH_IGNORE;
                end
            end
            PH_DLEN: begin
                e.role = urhd_pkg::ROLE_ADDR;
                name_len = b;
                if (b == 8'd0) begin
                    phase_q = PH_PORT_HI;
                end else begin
                    remaining = {8'd0, b}; phase_q = PH_ADDR;
                end
            end
            PH_ADDR: begin
                e.role = urhd_pkg::ROLE_ADDR;
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) phase_q = PH_PORT_HI;
            end
            PH_PORT_HI: begin
                e.role = urhd_pkg::ROLE_PORT; port_q = {b, 8'h00}; phase_q = PH_PORT_LO;
            end
            PH_PORT_LO: begin
                e.role = urhd_pkg::ROLE_PORT; port_q[7:0] = b; phase_q = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                e.role = urhd_pkg::ROLE_LENGTH; len_q = {b, 8'h00}; phase_q = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                e.role = urhd_pkg::ROLE_LENGTH; len_q[7:0] = b; phase_q = PH_CR;
            end
            PH_CR: begin
                e.role = urhd_pkg::ROLE_SEP;
                if (b != urhd_pkg::CHAR_CR) begin
                    status_q = urhd_pkg::ST_BAD_SEP; phase_q = PH_IGNORE;
                end else begin
                    phase_q = PH_LF;
                end
            end
            PH_LF: begin
                e.role = urhd_pkg::ROLE_SEP;
                if (b != urhd_pkg::CHAR_LF) begin
                    status_q = urhd_pkg::ST_BAD_SEP; phase_q = PH_IGNORE;
                end else if (len_q == 16'd0) begin
                    close_frame_ok();
                end else begin
                    remaining = len_q; phase_q = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                e.role = urhd_pkg::ROLE_PAYLOAD;
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) close_frame_ok();
            end
            default: begin
                e.role = urhd_pkg::ROLE_IGNORED;
            end
        endcase
        e.data     = b;
        e.status   = (last && status_q == urhd_pkg::ST_BUSY) ? urhd_pkg::ST_TRUNC : status_q;
        e.kind     = kind_q;
        e.port     = port_q;
        e.length   = len_q;
        e.consumed = (e.status == urhd_pkg::ST_OK) ? consumed_q : 17'd0;
        e.done     = last;
        expected_beats.push_back(e);
        if (last) clear_parser();
    endtask

    task automatic check_field(input string name, input logic [16:0] expv,
                               input logic [16:0] actv);
        if (actv !== expv) begin
            err_count++;
            $display("%0t %s: expected %0h actual %0h", $time, name, expv, actv);
        end
    endtask

    // result side: compare every transaction, then pick the next ready value
    always @(posedge aclk) begin
        beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                err_count++;
                $display("%0t unexpected result: expected none actual byte %0h",
                         $time, m_out_byte);
            end else begin
                e = expected_beats.pop_front();
                check_field("out_byte", 17'(e.data), 17'(m_out_byte));
                check_field("byte_role", 17'(e.role), 17'(m_byte_role));
                check_field("status", 17'(e.status), 17'(m_status));
                check_field("address_kind", 17'(e.kind), 17'(m_address_kind));
                check_field("port_number", 17'(e.port), 17'(m_port_number));
                check_field("payload_length", 17'(e.length), 17'(m_payload_length));
                check_field("consumed_count", e.consumed, m_consumed_count);
                check_field("frame_done", 17'(e.done), 17'(m_frame_done));
            end
        end
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            rx_hold = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // valid stays high across back-to-back transactions; it only drops for a gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_frame_last <= last;
        do @(posedge aclk); while (!s_ready);
        classify_byte(b, last);
        sent_count++;
    endtask

    task automatic send_frame(input octet_q_t f);
        for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic build_frame(input logic [7:0] atype, input logic [7:0] dlen,
                               input logic [15:0] port, input logic [15:0] len,
                               input logic [7:0] cr, input logic [7:0] lf,
                               input int trail, output octet_q_t f);
        f = {};
        f.push_back(atype);
        if (atype == urhd_pkg::ATYPE_V4) begin
            repeat (4) f.push_back(8'($urandom_range(0, 255)));
        end else if (atype == urhd_pkg::ATYPE_NAME) begin
            f.push_back(dlen);
            repeat (dlen) f.push_back(8'($urandom_range(0, 255)));
        end else if (atype == urhd_pkg::ATYPE_V6) begin
            repeat (16) f.push_back(8'($urandom_range(0, 255)));
        end
        f.push_back(port[15:8]);
        f.push_back(port[7:0]);
        f.push_back(len[15:8]);
        f.push_back(len[7:0]);
        f.push_back(cr);
        f.push_back(lf);
        repeat (len) f.push_back(8'($urandom_range(0, 255)));
        repeat (trail) f.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_beats.size() != 0);
    endtask

    task automatic test_ipv4_frames();
        octet_q_t f;
        // zero payload length finishes on the LF byte
        build_frame(urhd_pkg::ATYPE_V4, 8'd0, 16'hFFFF, 16'd0,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 0, f);
        send_frame(f);
        // bytes after the payload are ignored, status stays ok
        build_frame(urhd_pkg::ATYPE_V4, 8'd0, 16'h0000, 16'd3,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 2, f);
        send_frame(f);
    endtask

    task automatic test_domain_frames();
        octet_q_t f;
        // empty name: length byte goes straight to the port
        build_frame(urhd_pkg::ATYPE_NAME, 8'd0, 16'h1234, 16'd1,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 0, f);
        send_frame(f);
        build_frame(urhd_pkg::ATYPE_NAME, 8'd5, 16'h8001, 16'd2,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 1, f);
        send_frame(f);
    endtask

    task automatic test_ipv6_frame();
        octet_q_t f;
        build_frame(urhd_pkg::ATYPE_V6, 8'd0, 16'h00FF, 16'd4,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 0, f);
        send_frame(f);
    endtask

    task automatic test_header_errors();
        octet_q_t f;
        f = {8'h00, 8'h55, 8'hAA};
        send_frame(f);
        f = {8'hFF};
        send_frame(f);
        f = {8'h02, urhd_pkg::ATYPE_V4, urhd_pkg::CHAR_CR};
        send_frame(f);
        build_frame(urhd_pkg::ATYPE_V4, 8'd0, 16'h5A5A, 16'd1,
                    urhd_pkg::CHAR_LF, urhd_pkg::CHAR_LF, 1, f);
        send_frame(f);
        build_frame(urhd_pkg::ATYPE_NAME, 8'd1, 16'hA5A5, 16'd1,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_CR, 0, f);
        send_frame(f);
        // truncated inside a max-length payload
        build_frame(urhd_pkg::ATYPE_V4, 8'd0, 16'h0102, 16'd0,
                    urhd_pkg::CHAR_CR, urhd_pkg::CHAR_LF, 3, f);
        f[7] = 8'hFF;
        f[8] = 8'hFF;
        send_frame(f);
        // truncated inside an IPv6 address, and on a lone valid type byte
        f = {urhd_pkg::ATYPE_V6, 8'h20, 8'h01, 8'h0D, 8'h0A, 8'hFE};
        send_frame(f);
        f = {urhd_pkg::ATYPE_V4};
        send_frame(f);
    endtask

    task automatic test_random_traffic(input int target);
        octet_q_t    f;
        int          start;
        int          mode;
        int          sel;
        int          keep;
        logic [7:0]  atype;
        logic [7:0]  dlen;
        logic [15:0] len;
        logic [15:0] wide_len;
        logic [7:0]  cr;
        logic [7:0]  lf;
        start = sent_count;
        while (sent_count - start < target) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                // noise burst
                f = {};
                repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(0, 255)));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 30) atype = urhd_pkg::ATYPE_V4;
                else if (sel < 60) atype = urhd_pkg::ATYPE_NAME;
                else if (sel < 85) atype = urhd_pkg::ATYPE_V6;
                else atype = 8'($urandom_range(0, 255));
                dlen = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(200, 255))
                                                    : 8'($urandom_range(0, 12));
                len  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(17, 300))
                                                    : 16'($urandom_range(0, 16));
                cr = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255))
                                                  : urhd_pkg::CHAR_CR;
                lf = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255))
                                                  : urhd_pkg::CHAR_LF;
                if (mode == 1) begin
                    // full-range length, possibly cut short somewhere
                    build_frame(atype, dlen, 16'($urandom_range(0, 65535)), 16'd0, cr, lf,
                                0, f);
                    wide_len = 16'($urandom_range(0, 65535));
                    f[f.size() - 4] = wide_len[15:8];
                    f[f.size() - 3] = wide_len[7:0];
                    repeat ($urandom_range(0, 6)) f.push_back(8'($urandom_range(0, 255)));
                    keep = $urandom_range(1, f.size());
                    while (f.size() > keep) void'(f.pop_back());
                end else begin
                    build_frame(atype, dlen, 16'($urandom_range(0, 65535)), len, cr, lf,
                                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0, f);
                end
            end
            send_frame(f);
        end
    endtask

    initial begin
        clear_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ipv4_frames();
        test_domain_frames();
        test_ipv6_frame();
        test_header_errors();
        test_random_traffic(900);
        wait_results_drained();
        test_random_traffic(500);
        idle_on = 1'b0;
        test_random_traffic(350);
        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/urhd_pkg.sv
src/urhd_front.sv
src/urhd_queue.sv
src/urhd_back.sv
src/udp_relay_header_deframer.sv
verif/tb_top.sv
